// File: rtl/core/sfd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfd_pkg
// Types and constants shared by the serial frame deframer modules.
// ----------------------------------------------------------------------------
package sfd_pkg;

  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_HEADER    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LEN_LIMIT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DATA_CMD  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SUB_LIMIT = 2'd3;

  localparam logic [7:0] HEADER_RST    = 8'hA5;
  localparam logic [7:0] LEN_LIMIT_RST = 8'd200;
  localparam logic [7:0] DATA_CMD_RST  = 8'h04;
  localparam logic [7:0] SUB_LIMIT_RST = 8'd16;

  localparam logic [1:0] ST_NONE   = 2'd0;
  localparam logic [1:0] ST_REJECT = 2'd1;
  localparam logic [1:0] ST_DATA   = 2'd2;

  localparam logic [7:0] IDX_LEN = 8'd1;
  localparam logic [7:0] IDX_CMD = 8'd3;
  localparam logic [7:0] IDX_SUB = 8'd5;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       chunk_end;
  } sfd_in_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [63:0] payload_word;
    logic [3:0]  byte_count;
    logic        last;
  } sfd_out_t;

  typedef struct packed {
    logic       en;
    logic [7:0] addr;
    logic [7:0] data;
  } sfd_wr_t;

  typedef struct packed {
    logic [1:0] status;
    logic [7:0] len;
  } sfd_desc_t;

endpackage

// File: rtl/core/sfd_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfd_front
// Accepts bytes, tracks the frame, writes the frame store and queues one
// report descriptor per chunk end.
// ----------------------------------------------------------------------------
module sfd_front
  import sfd_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  sfd_in_t              in_item,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]           cfg_data,
  input  logic                 q_full,
  output logic                 q_push,
  output sfd_desc_t            q_desc,
  output sfd_wr_t              wr,
  input  logic                 pay_done
);

  logic [7:0] header_r, len_limit_r, data_cmd_r, sub_limit_r;
  logic [7:0] idx_r, idx_nxt;
  logic [7:0] sum_r, sum_nxt;
  logic       done_r, done_nxt;
  logic       discard_r, discard_nxt;
  logic       in_frame_r, in_frame_nxt;
  logic       lock_r, lock_nxt;
  logic [7:0] len_r, len_nxt;
  logic [7:0] cmd_r, cmd_nxt;
  logic [7:0] sub_r, sub_nxt;
  logic [7:0] len_v;
  logic [7:0] b;
  logic       in_fire;

  assign in_ready  = !q_full && !lock_r;
  assign cfg_ready = 1'b1;
  assign in_fire   = in_valid && in_ready;
  assign b         = in_item.rx_byte;

  always_comb begin
    idx_nxt      = idx_r;
    sum_nxt      = sum_r;
    done_nxt     = done_r;
    discard_nxt  = discard_r;
    in_frame_nxt = in_frame_r;
    lock_nxt     = lock_r;
    len_nxt      = len_r;
    cmd_nxt      = cmd_r;
    sub_nxt      = sub_r;
    len_v        = len_r;
    wr           = '0;
    q_push       = 1'b0;
    q_desc       = '0;
    if (pay_done) begin
      lock_nxt = 1'b0;
    end
    if (in_fire) begin
      if (discard_r) begin
        discard_nxt = 1'b0;
      end else if (!in_frame_r) begin
        if (b == header_r) begin
          in_frame_nxt = 1'b1;
          done_nxt     = 1'b0;
          wr.en        = 1'b1;
          wr.addr      = 8'd0;
          wr.data      = b;
          idx_nxt      = 8'd1;
          sum_nxt      = b;
        end
      end else if (!done_r) begin
        wr.en   = 1'b1;
        wr.addr = idx_r;
        wr.data = b;
        len_v   = (idx_r == IDX_LEN) ? b : len_r;
        if (idx_r == IDX_LEN) begin
          len_nxt = b;
        end
        if (idx_r == IDX_CMD) begin
          cmd_nxt = b;
        end
        if (idx_r == IDX_SUB) begin
          sub_nxt = b;
        end
        if (idx_r > 8'd2 && ({1'b0, idx_r} + 9'd1 >= {1'b0, len_v})) begin
          done_nxt = 1'b1;
          sum_nxt  = sum_r - b;
        end else begin
          sum_nxt = sum_r + b;
          idx_nxt = idx_r + 8'd1;
        end
        if (len_v > len_limit_r) begin
          in_frame_nxt = 1'b0;
          done_nxt     = 1'b0;
          idx_nxt      = 8'd0;
          sum_nxt      = 8'd0;
          len_nxt      = 8'd0;
          discard_nxt  = 1'b1;
        end
      end
      if (in_item.chunk_end) begin
        q_push      = 1'b1;
        q_desc.len  = len_nxt;
        q_desc.status = ST_NONE;
        if (done_nxt && sum_nxt == 8'd0) begin
          if (cmd_nxt == data_cmd_r && sub_nxt != 8'd0 && sub_nxt < sub_limit_r) begin
            q_desc.status = ST_DATA;
            lock_nxt      = 1'b1;
          end else begin
            q_desc.status = ST_REJECT;
          end
        end
        if (done_nxt) begin
          in_frame_nxt = 1'b0;
          done_nxt     = 1'b0;
          idx_nxt      = 8'd0;
          sum_nxt      = 8'd0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      header_r    <= HEADER_RST;
      len_limit_r <= LEN_LIMIT_RST;
      data_cmd_r  <= DATA_CMD_RST;
      sub_limit_r <= SUB_LIMIT_RST;
      idx_r       <= 8'd0;
      sum_r       <= 8'd0;
      done_r      <= 1'b0;
      discard_r   <= 1'b0;
      in_frame_r  <= 1'b0;
      lock_r      <= 1'b0;
    end else begin
      idx_r      <= idx_nxt;
      sum_r      <= sum_nxt;
      done_r     <= done_nxt;
      discard_r  <= discard_nxt;
      in_frame_r <= in_frame_nxt;
      lock_r     <= lock_nxt;
      if (cfg_valid) begin
        unique case (cfg_index)
          CFG_HEADER:    header_r    <= cfg_data;
          CFG_LEN_LIMIT: len_limit_r <= cfg_data;
          CFG_DATA_CMD:  data_cmd_r  <= cfg_data;
          CFG_SUB_LIMIT: sub_limit_r <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    len_r <= len_nxt;
    cmd_r <= cmd_nxt;
    sub_r <= sub_nxt;
  end

endmodule

// File: rtl/core/sfd_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfd_queue
// Two-entry queue of report descriptors between front and back.
// ----------------------------------------------------------------------------
module sfd_queue
  import sfd_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  sfd_desc_t push_desc,
  input  logic      pop,
  output sfd_desc_t pop_desc,
  output logic      full,
  output logic      empty
);

  sfd_desc_t  entry_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r, count_nxt;
  logic       do_push, do_pop;

  assign full     = (count_r == 2'd2);
  assign empty    = (count_r == 2'd0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_desc = entry_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = do_push ? !wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = do_pop ? !rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + 2'd1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wr_ptr_r] <= push_desc;
    end
  end

endmodule

// File: rtl/core/sfd_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfd_back
// Holds the frame store, turns report descriptors into result items and
// packs payload bytes into 8-byte words behind an output register.
// ----------------------------------------------------------------------------
module sfd_back
  import sfd_pkg::*;
#(
  parameter int FRAME_BYTES = 256
) (
  input  logic      clk,
  input  logic      rst_n,
  input  sfd_wr_t   wr,
  input  logic      q_empty,
  input  sfd_desc_t q_desc,
  output logic      q_pop,
  output logic      out_valid,
  input  logic      out_ready,
  output sfd_out_t  out_item,
  output logic      pay_done
);

  localparam int AW = $clog2(FRAME_BYTES);

  typedef enum logic [1:0] {S_IDLE, S_READ, S_CAPT, S_SEND} state_t;

  state_t      state_r;
  logic [7:0]  mem [FRAME_BYTES];
  logic [7:0]  rd_data_r;
  logic        rd_ok_r;
  logic        wr_ok;
  logic        rd_ok;
  logic [7:0]  len_r;
  logic [7:0]  off_r;
  logic [2:0]  slot_r;
  logic [63:0] word_r;
  logic [3:0]  cnt_r;
  logic [1:0]  status_r;
  logic        last_r;
  logic        out_valid_r;
  sfd_out_t    out_item_r;
  logic        can_load;
  logic [7:0]  byte_v;
  logic [7:0]  off_inc;

  assign wr_ok     = (9'(wr.addr) < 9'(FRAME_BYTES));
  assign rd_ok     = (9'(off_r) < 9'(FRAME_BYTES));
  assign can_load  = !out_valid_r || out_ready;
  assign q_pop     = (state_r == S_IDLE) && !q_empty;
  assign pay_done  = (state_r == S_SEND) && can_load && last_r && (status_r == ST_DATA);
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;
  assign byte_v    = rd_ok_r ? rd_data_r : 8'd0;
  assign off_inc   = off_r + 8'd1;

  always_ff @(posedge clk) begin
    if (wr.en && wr_ok) begin
      mem[wr.addr[AW-1:0]] <= wr.data;
    end
    if (state_r == S_READ) begin
      rd_data_r <= mem[off_r[AW-1:0]];
      rd_ok_r   <= rd_ok;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      if (state_r == S_SEND && can_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (!q_empty) begin
            status_r <= q_desc.status;
            len_r    <= q_desc.len;
            off_r    <= 8'd0;
            slot_r   <= 3'd0;
            word_r   <= 64'd0;
            cnt_r    <= 4'd0;
            if (q_desc.status != ST_DATA || q_desc.len == 8'd0) begin
              last_r  <= 1'b1;
              state_r <= S_SEND;
            end else begin
              last_r  <= 1'b0;
              state_r <= S_READ;
            end
          end
        end
        S_READ: begin
          state_r <= S_CAPT;
        end
        S_CAPT: begin
          word_r[{slot_r, 3'b000} +: 8] <= byte_v;
          off_r  <= off_inc;
          slot_r <= slot_r + 3'd1;
          if (off_inc == len_r || slot_r == 3'd7) begin
            cnt_r   <= {1'b0, slot_r} + 4'd1;
            last_r  <= (off_inc == len_r);
            state_r <= S_SEND;
          end else begin
            state_r <= S_READ;
          end
        end
        S_SEND: begin
          if (can_load) begin
            out_item_r.status       <= status_r;
            out_item_r.payload_word <= word_r;
            out_item_r.byte_count   <= cnt_r;
            out_item_r.last         <= last_r;
            if (last_r) begin
              state_r <= S_IDLE;
            end else begin
              slot_r  <= 3'd0;
              word_r  <= 64'd0;
              state_r <= S_READ;
            end
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

// File: rtl/core/serial_frame_deframer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// serial_frame_deframer
// Collects received bytes into frames and reports one status per host chunk.
//
// Input channel in_*: one received byte and its chunk_end flag per item,
// taken whenever in_ready is high. Bytes that do not end a chunk produce
// no result. A chunk end queues a report for the back end.
// Output channel out_*: a reject or no-frame report is one item, loaded
// into the output register after it leaves the queue. An accepted frame
// gives ceil(L/8) items, one when L is 0, read from the frame store one
// byte at a time (read, then capture state) through the single read port
// and sent a word at a time; the input stalls until the last is loaded.
// cfg_*: register writes, always ready; write them only while the block is
// idle. Reset (rst_n low, synchronous) clears frame tracking, the report
// queue and the output register and restores the register defaults; the
// frame store is left as is. A stalled receiver holds the output register;
// up to two reports queue up, after which in_ready drops.
// ----------------------------------------------------------------------------
module serial_frame_deframer
  import sfd_pkg::*;
#(
  parameter int FRAME_BYTES = 256
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  sfd_in_t              in_item,
  output logic                 out_valid,
  input  logic                 out_ready,
  output sfd_out_t             out_item,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]           cfg_data
);

  logic      q_full, q_empty, q_push, q_pop, pay_done;
  sfd_desc_t push_desc, pop_desc;
  sfd_wr_t   wr;

  sfd_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_desc    (push_desc),
    .wr        (wr),
    .pay_done  (pay_done)
  );

  sfd_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_desc (push_desc),
    .pop       (q_pop),
    .pop_desc  (pop_desc),
    .full      (q_full),
    .empty     (q_empty)
  );

  sfd_back #(
    .FRAME_BYTES (FRAME_BYTES)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .wr        (wr),
    .q_empty   (q_empty),
    .q_desc    (pop_desc),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item),
    .pay_done  (pay_done)
  );

endmodule

// File: rtl/core/sfd_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfd_checker
// Port-level checks on the result channel of the deframer.
// ----------------------------------------------------------------------------
module sfd_checker
  import sfd_pkg::*;
(
  input logic     clk,
  input logic     rst_n,
  input logic     out_valid,
  input logic     out_ready,
  input sfd_out_t out_item
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_item))
    else $error("result item changed while stalled");

  a_plain_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.status != ST_DATA |->
      out_item.last && out_item.byte_count == 4'd0 && out_item.payload_word == 64'd0)
    else $error("status-only report carries payload");

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_item.byte_count <= 4'd8)
    else $error("byte count above eight");

  a_full_word: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.status == ST_DATA && !out_item.last |->
      out_item.byte_count == 4'd8)
    else $error("non-final payload word is partial");

endmodule

bind serial_frame_deframer sfd_checker u_sfd_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_item  (out_item)
);

// File: sim/serial_frame_deframer_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// serial_frame_deframer_tb
// Sends received bytes through the deframer and checks every chunk report
// against a behavioral frame tracker kept in the bench. A short table of
// directed bytes comes first: empty reports, an open frame across a chunk
// end, an oversized length with the discarded byte, a rejected command with
// a trailing byte, and a zero-length frame on a stale sub byte. Random frames,
// aborts and noise follow under several register settings, with random
// stalls on both sides and one long receiver stall.
// ----------------------------------------------------------------------------
module serial_frame_deframer_tb;
  import sfd_pkg::*;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int HOLD_CYCLES    = 300;
  localparam int SHOW_MAX       = 30;

  typedef struct packed {
    logic [7:0] rx;
    logic       ends;
    logic       typed;
    logic [1:0] st;
  } dir_row_t;

  logic                 clk;
  logic                 rst_n     = 1'b0;
  logic                 in_valid  = 1'b0;
  logic                 in_ready;
  sfd_in_t              in_item   = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  sfd_out_t             out_item;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_HEADER;
  logic [7:0]           cfg_data  = '0;

  serial_frame_deframer u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_item (out_item),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  logic [7:0] frame_mem [0:255];
  logic [7:0] next_pos = '0;
  logic [7:0] sum_acc  = '0;
  bit         frame_open;
  bit         frame_complete;
  bit         drop_next;
  logic [7:0] hdr_val = HEADER_RST;
  logic [7:0] len_max = LEN_LIMIT_RST;
  logic [7:0] cmd_val = DATA_CMD_RST;
  logic [7:0] sub_max = SUB_LIMIT_RST;

  sfd_out_t new_reports[$];
  sfd_out_t expected_reports[$];
  sfd_out_t want;

  int err_count    = 0;
  int items_sent   = 0;
  int checked      = 0;
  int word_count   = 0;
  int reject_count = 0;
  int none_count   = 0;
  int idle_cycles  = 0;
  bit calm         = 1'b0;
  bit hold_req     = 1'b0;

  dir_row_t dir_rows [0:18] = '{
    '{8'h00,         1'b1, 1'b1, ST_NONE},
    '{HEADER_RST,    1'b0, 1'b0, ST_NONE},
    '{8'h06,         1'b1, 1'b1, ST_NONE},
    '{8'h00,         1'b0, 1'b0, ST_NONE},
    '{DATA_CMD_RST,  1'b0, 1'b0, ST_NONE},
    '{8'h55,         1'b0, 1'b0, ST_NONE},
    '{8'h04,         1'b1, 1'b0, ST_NONE},
    '{HEADER_RST,    1'b0, 1'b0, ST_NONE},
    '{8'hFF,         1'b1, 1'b1, ST_NONE},
    '{HEADER_RST,    1'b1, 1'b1, ST_NONE},
    '{HEADER_RST,    1'b0, 1'b0, ST_NONE},
    '{8'h04,         1'b0, 1'b0, ST_NONE},
    '{8'h00,         1'b0, 1'b0, ST_NONE},
    '{8'hA9,         1'b0, 1'b0, ST_NONE},
    '{8'hFF,         1'b1, 1'b1, ST_REJECT},
    '{HEADER_RST,    1'b0, 1'b0, ST_NONE},
    '{8'h00,         1'b0, 1'b0, ST_NONE},
    '{8'h5F,         1'b0, 1'b0, ST_NONE},
    '{DATA_CMD_RST,  1'b1, 1'b0, ST_NONE}
  };

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic void clear_frame();
    frame_open     = 1'b0;
    frame_complete = 1'b0;
    next_pos       = '0;
    sum_acc        = '0;
  endfunction

  function automatic void deframe_byte(input sfd_in_t it);
    int         idx;
    int         len;
    int         off;
    int         cnt;
    int         i;
    logic [1:0] st;
    sfd_out_t   r;
    new_reports.delete();
    if (drop_next) begin
      drop_next = 1'b0;
    end else if (!frame_open) begin
      if (it.rx_byte == hdr_val) begin
        frame_open     = 1'b1;
        frame_complete = 1'b0;
        frame_mem[0]   = it.rx_byte;
        next_pos       = 8'd1;
        sum_acc        = it.rx_byte;
      end
    end else if (!frame_complete) begin
      idx = int'(next_pos);
      frame_mem[8'(idx)] = it.rx_byte;
      len = (idx == 1) ? int'(it.rx_byte) : int'(frame_mem[IDX_LEN]);
      if (idx > 2 && idx >= len - 1) begin
        frame_complete = 1'b1;
        sum_acc = sum_acc - it.rx_byte;
      end else begin
        sum_acc  = sum_acc + it.rx_byte;
        next_pos = next_pos + 8'd1;
      end
      if (len > len_max) begin
        frame_mem[0] = '0;
        frame_mem[1] = '0;
        frame_mem[7] = '0;
        clear_frame();
        drop_next = 1'b1;
      end
    end
    if (it.chunk_end) begin
      st = ST_NONE;
      if (frame_complete && sum_acc == 8'd0) begin
        st = (frame_mem[IDX_CMD] == cmd_val && frame_mem[IDX_SUB] != 8'd0 &&
              frame_mem[IDX_SUB] < sub_max) ? ST_DATA : ST_REJECT;
      end
      if (st == ST_DATA) begin
        len = int'(frame_mem[IDX_LEN]);
        off = 0;
        do begin
          cnt = (len - off > 8) ? 8 : len - off;
          r = '0;
          r.status = ST_DATA;
          for (i = 0; i < cnt; i++) r.payload_word[8*i +: 8] = frame_mem[8'(off + i)];
          off += cnt;
          r.byte_count = 4'(cnt);
          r.last = (off >= len);
          new_reports.insert(new_reports.size(), r);
        end while (off < len);
      end else begin
        r = '0;
        r.status = st;
        r.last = 1'b1;
        new_reports.insert(new_reports.size(), r);
      end
      if (frame_complete) clear_frame();
    end
  endfunction

  task automatic send_byte(input logic [7:0] b, input logic e,
                           input bit typed = 1'b0, input logic [1:0] st = ST_NONE);
    sfd_in_t  it;
    sfd_out_t r;
    it.rx_byte = b;
    it.chunk_end = e;
    if (!calm && $urandom_range(0, 7) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    items_sent++;
    deframe_byte(it);
    if (typed && e) begin
      r = '0;
      r.status = st;
      r.last = 1'b1;
      expected_reports.insert(expected_reports.size(), r);
    end else begin
      foreach (new_reports[k]) expected_reports.insert(expected_reports.size(), new_reports[k]);
    end
  endtask

  task automatic drain_all(input int extra);
    in_valid <= 1'b0;
    do @(posedge clk); while (expected_reports.size() != 0);
    repeat (extra) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] v);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      CFG_HEADER:    hdr_val = v;
      CFG_LEN_LIMIT: len_max = v;
      CFG_DATA_CMD:  cmd_val = v;
      default:       sub_max = v;
    endcase
  endtask

  task automatic set_regs(input logic [7:0] h, input logic [7:0] l,
                          input logic [7:0] c, input logic [7:0] s);
    drain_all(8);
    write_reg(CFG_HEADER, h);
    write_reg(CFG_LEN_LIMIT, l);
    write_reg(CFG_DATA_CMD, c);
    write_reg(CFG_SUB_LIMIT, s);
    cfg_valid <= 1'b0;
  endtask

  task automatic run_random(input int target, input bit big_first);
    int         start;
    int         len;
    int         n;
    int         cut;
    int         pick;
    int         lastp;
    int         i;
    logic [7:0] fb[$];
    logic [7:0] s;
    start = items_sent;
    while (items_sent - start < target || frame_open || drop_next) begin
      fb.delete();
      cut = -1;
      if (drop_next) begin
        send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0);
      end else if (frame_open && next_pos == 8'd1) begin
        send_byte(8'($urandom_range(0, len_max < 20 ? len_max : 20)), 1'b0);
      end else if (frame_open && !frame_complete) begin
        // finish the open frame with a good checksum
        lastp = int'(frame_mem[IDX_LEN]) - 1;
        if (lastp < 3) lastp = 3;
        while (next_pos < lastp) send_byte(8'($urandom_range(0, 255)), 1'b0);
        send_byte(sum_acc, 1'b1);
      end else if (frame_open) begin
        send_byte(8'($urandom_range(0, 255)), 1'b1);
      end else begin
        pick = $urandom_range(0, 99);
        if (big_first || pick < 72) begin
          if (big_first) len = (len_max < 72) ? len_max : 72;
          else if ($urandom_range(0, 29) == 0) len = $urandom_range(0, len_max < 60 ? len_max : 60);
          else len = $urandom_range(0, len_max < 20 ? len_max : 20);
          big_first = 1'b0;
          n = (len > 4) ? len : 4;
          fb.insert(fb.size(), hdr_val);
          fb.insert(fb.size(), 8'(len));
          for (i = 2; i < n - 1; i++) fb.insert(fb.size(), 8'($urandom_range(0, 255)));
          if (n > 4 && $urandom_range(0, 4) != 0) fb[3] = cmd_val;
          if (n > 6 && $urandom_range(0, 4) != 0)
            fb[5] = (sub_max > 1) ? 8'($urandom_range(1, sub_max - 1)) :
                                    8'($urandom_range(0, 255));
          if (n == 4 && $urandom_range(0, 1) == 1) fb[2] = cmd_val - hdr_val - 8'(len);
          s = '0;
          foreach (fb[k]) s = s + fb[k];
          if ($urandom_range(0, 6) == 0) s = s ^ (8'd1 << $urandom_range(0, 7));
          fb.insert(fb.size(), s);
          if ($urandom_range(0, 9) == 0) cut = $urandom_range(0, n - 2);
          if ($urandom_range(0, 4) == 0)
            repeat ($urandom_range(1, 3)) fb.insert(fb.size(), 8'($urandom_range(0, 255)));
        end else if (pick < 86 && len_max != 8'd255) begin
          fb.insert(fb.size(), hdr_val);
          fb.insert(fb.size(), 8'($urandom_range(len_max + 1, 255)));
          repeat ($urandom_range(0, 3)) fb.insert(fb.size(), 8'($urandom_range(0, 255)));
        end else if (pick < 95) begin
          repeat ($urandom_range(1, 5)) fb.insert(fb.size(), 8'($urandom_range(0, 255)));
        end else begin
          drain_all(0);
        end
        foreach (fb[k]) send_byte(fb[k], (k == fb.size() - 1) || (k == cut));
      end
    end
  endtask

  initial begin
    forever begin
      @(posedge clk);
      if (hold_req) begin
        // hold off the receiver so reports back up and the input stalls
        hold_req = 1'b0;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 14)) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      checked++;
      if (out_item.status == ST_DATA) word_count++;
      else if (out_item.status == ST_REJECT) reject_count++;
      else none_count++;
      if (expected_reports.size() == 0) begin
        err_count++;
        if (err_count <= SHOW_MAX)
          $display("%0t: unexpected result: status %0d word %h count %0d last %b", $time,
                   out_item.status, out_item.payload_word, out_item.byte_count, out_item.last);
      end else begin
        want = expected_reports.pop_front();
        if (out_item !== want) begin
          err_count++;
          if (err_count <= SHOW_MAX)
            $display("%0t: expected status %0d word %h count %0d last %b, got %0d %h %0d %b",
                     $time, want.status, want.payload_word, want.byte_count, want.last,
                     out_item.status, out_item.payload_word, out_item.byte_count,
                     out_item.last);
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no handshake for %0d cycles, %0d results outstanding", $time,
               idle_cycles, expected_reports.size());
      $display("end of test: mismatches");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    logic [7:0] b;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    set_regs(HEADER_RST, LEN_LIMIT_RST, DATA_CMD_RST, SUB_LIMIT_RST);
    foreach (dir_rows[k])
      send_byte(dir_rows[k].rx, dir_rows[k].ends, dir_rows[k].typed, dir_rows[k].st);

    hold_req = 1'b1;
    repeat (16) begin
      b = 8'($urandom_range(0, 255));
      if (b == hdr_val) b = b ^ 8'd1;
      send_byte(b, 1'b1);
    end
    run_random(60, 1'b0);

    set_regs(8'h00, 8'd0, 8'hFF, 8'd1);
    run_random(30, 1'b0);
    set_regs(8'hFF, 8'd255, 8'h00, 8'd255);
    run_random(80, 1'b1);
    calm = 1'b1;
    set_regs(8'h7E, 8'd40, 8'h11, 8'd9);
    run_random(50, 1'b0);

    drain_all(20);
    $display("sent %0d bytes under four register settings, with a %0d-cycle receiver stall",
             items_sent, HOLD_CYCLES);
    $display("checked %0d results: %0d data words, %0d rejects, %0d empty reports",
             checked, word_count, reject_count, none_count);
    if (err_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
